// ----- sv/wvn_pkg.sv -----
`timescale 1ns / 1ps

package wvn_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int NORM_W           = 32;
    localparam int ACC_W            = 64;
    localparam int SQRT_STEPS       = ACC_W / 2;
    localparam int FIFO_DEPTH       = 4;

    localparam logic MODE_INF = 1'b0;
    localparam logic MODE_L2  = 1'b1;

    typedef struct packed {
        logic [NORM_W-1:0] norm_value;
        logic              overflowed;
    } wvn_result_t;

endpackage

// ----- sv/weighted_vector_norm.sv -----
`timescale 1ns / 1ps
// Result path: product register, queue, square stage and statistics update;
// an L2-norm result also passes the square root state (one root bit per cycle).
// Throughput: one element per cycle within a vector while the queue is not full;
// after the last element the back end pops nothing until the result is taken.
// Reset: rst_n is asynchronous, active low; clears the pipeline, queue and
// statistics, and sets norm_mode to the infinity norm.

module weighted_vector_norm #(
    parameter int SAMPLE_WIDTH = wvn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [0:0]                                cfg_data,      // norm_mode
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // element_value, element_weight, zero padding
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                      s_axis_tlast,  // last_element
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [wvn_pkg::NORM_W-1:0]                m_axis_tdata,  // norm_value
    output logic                                      m_axis_tuser   // overflowed
);

    localparam int ENTRY_W = 2 * SAMPLE_WIDTH;

    logic                 norm_mode_reg;
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 empty;
    logic [ENTRY_W-1:0]   push_data;
    logic [ENTRY_W-1:0]   rd_data;
    wvn_pkg::wvn_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= wvn_pkg::MODE_INF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            norm_mode_reg <= cfg_data[0];
        end
    end

    wvn_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .element_value  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .element_weight (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .last_element   (s_axis_tlast),
        .push           (push),
        .full           (full),
        .push_data      (push_data)
    );

    wvn_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (wvn_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_data),
        .empty   (empty)
    );

    wvn_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .norm_mode (norm_mode_reg),
        .rd_data   (rd_data),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = result.norm_value;
    assign m_axis_tuser = result.overflowed;

endmodule

// ----- sv/wvn_front.sv -----
`timescale 1ns / 1ps

module wvn_front #(
    parameter int SAMPLE_WIDTH = wvn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [SAMPLE_WIDTH-1:0]   element_value,
    input  logic [SAMPLE_WIDTH-1:0]   element_weight,
    input  logic                      last_element,
    output logic                      push,
    input  logic                      full,
    output logic [2*SAMPLE_WIDTH-1:0] push_data
);

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int MAG_W  = PROD_W - 1;

    logic              p_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              last_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] mag_full;

    assign prod_next = PROD_W'($signed(element_value) * $signed(element_weight));

    // The largest magnitude is 2^(PROD_W-2), so one bit less than the product holds it.
    assign mag_full  = prod_reg[PROD_W-1] ? (PROD_W'(0) - prod_reg) : prod_reg;
    assign push      = p_valid_reg && !full;
    assign in_ready  = !p_valid_reg || !full;
    assign push_data = {last_reg, mag_full[MAG_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
            last_reg <= last_element;
        end
    end

endmodule

// ----- sv/wvn_fifo.sv -----
`timescale 1ns / 1ps

module wvn_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = wvn_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == CNT_W'(0));
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/wvn_back.sv -----
`timescale 1ns / 1ps

module wvn_back #(
    parameter int SAMPLE_WIDTH = wvn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      norm_mode,
    input  logic [2*SAMPLE_WIDTH-1:0] rd_data,
    input  logic                      empty,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output wvn_pkg::wvn_result_t      result
);

    localparam int MAG_W  = 2 * SAMPLE_WIDTH - 1;
    localparam int ACC_W  = wvn_pkg::ACC_W;
    localparam int NORM_W = wvn_pkg::NORM_W;
    localparam int CNT_W  = $clog2(wvn_pkg::SQRT_STEPS);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_SQRT = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg;

    // Square stage.
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              s1_big_reg;
    logic [MAG_W-1:0]  s1_mag_reg;
    logic [ACC_W-1:0]  s1_sq_reg;

    // Per-vector statistics.
    logic [MAG_W-1:0]  max_reg;
    logic [ACC_W-1:0]  sum_reg;
    logic              sat_reg;

    // Square root unit.
    logic [ACC_W-1:0]  x_reg;
    logic [ACC_W-1:0]  res_reg;
    logic [ACC_W-1:0]  bit_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              flag_reg;

    wvn_pkg::wvn_result_t result_reg;

    logic [MAG_W-1:0]  pop_mag;
    logic [ACC_W-1:0]  pop_mag_ext;
    logic              pop_big;
    logic [ACC_W-1:0]  pop_sq;
    logic [MAG_W-1:0]  max_next;
    logic [ACC_W:0]    sum_add;
    logic              ovf;
    logic [ACC_W-1:0]  sum_next;
    logic              sat_next;
    logic [ACC_W-1:0]  max_ext;
    logic [NORM_W-1:0] max_sat;
    logic [ACC_W-1:0]  trial;
    logic              take;
    logic [ACC_W-1:0]  res_next;

    assign pop = !empty && (state_reg == ST_ACC) && !(s1_valid_reg && s1_last_reg);

    assign pop_mag     = rd_data[MAG_W-1:0];
    assign pop_mag_ext = ACC_W'(pop_mag);
    assign pop_big     = (pop_mag_ext[ACC_W-1:NORM_W] != '0);
    assign pop_sq      = pop_mag_ext[NORM_W-1:0] * pop_mag_ext[NORM_W-1:0];

    assign max_next = (s1_mag_reg > max_reg) ? s1_mag_reg : max_reg;
    assign sum_add  = {1'b0, sum_reg} + {1'b0, s1_sq_reg};
    assign ovf      = s1_big_reg || sum_add[ACC_W];
    assign sum_next = ovf ? '1 : sum_add[ACC_W-1:0];
    assign sat_next = sat_reg || ovf;
    assign max_ext  = ACC_W'(max_next);
    assign max_sat  = (max_ext[ACC_W-1:NORM_W] != '0) ? '1 : max_ext[NORM_W-1:0];

    // One result bit per step; the root of a 64-bit value always fits in 32 bits.
    assign trial    = res_reg + bit_reg;
    assign take     = (x_reg >= trial);
    assign res_next = take ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    assign out_valid = (state_reg == ST_OUT);
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_ACC;
            s1_valid_reg <= 1'b0;
            max_reg      <= '0;
            sum_reg      <= '0;
            sat_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= pop;
            case (state_reg)
                ST_ACC:
                begin
                    if (s1_valid_reg)
                    begin
                        if (s1_last_reg)
                        begin
                            max_reg <= '0;
                            sum_reg <= '0;
                            sat_reg <= 1'b0;
                            cnt_reg <= CNT_W'(wvn_pkg::SQRT_STEPS - 1);
                            if (norm_mode == wvn_pkg::MODE_L2)
                            begin
                                state_reg <= ST_SQRT;
                            end
                            else
                            begin
                                state_reg <= ST_OUT;
                            end
                        end
                        else
                        begin
                            max_reg <= max_next;
                            sum_reg <= sum_next;
                            sat_reg <= sat_next;
                        end
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                default:
                begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_last_reg <= rd_data[MAG_W];
            s1_big_reg  <= pop_big;
            s1_mag_reg  <= pop_mag;
            s1_sq_reg   <= pop_sq;
        end
        if ((state_reg == ST_ACC) && s1_valid_reg && s1_last_reg)
        begin
            x_reg    <= sum_next;
            res_reg  <= '0;
            bit_reg  <= ACC_W'(1) << (ACC_W - 2);
            flag_reg <= sat_next;
            result_reg.norm_value <= max_sat;
            result_reg.overflowed <= 1'b0;
        end
        else if (state_reg == ST_SQRT)
        begin
            if (take)
            begin
                x_reg <= x_reg - trial;
            end
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
            if (cnt_reg == '0)
            begin
                result_reg.norm_value <= res_next[NORM_W-1:0];
                result_reg.overflowed <= flag_reg;
            end
        end
    end

endmodule

// ----- sv/wvn_checker.sv -----
`timescale 1ns / 1ps

module wvn_checker #(
    parameter int SAMPLE_WIDTH = wvn_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [0:0]                          cfg_data,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tlast,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [wvn_pkg::NORM_W-1:0]          m_axis_tdata,
    input logic                                m_axis_tuser
);

    logic       mode_reg;
    logic [3:0] open_reg;
    logic       in_last;
    logic       out_done;

    assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_done = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= wvn_pkg::MODE_INF;
            open_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data[0];
            end
            if (in_last && !out_done)
            begin
                open_reg <= open_reg + 1'b1;
            end
            else if (out_done && !in_last)
            begin
                open_reg <= open_reg - 1'b1;
            end
        end
    end

    // A result waiting to be taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Every result belongs to a vector whose last element came in.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> open_reg != 4'd0)
        else $error("result without a finished vector");

    // The infinity norm never reports a saturated sum.
    a_inf_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && mode_reg == wvn_pkg::MODE_INF |-> !m_axis_tuser)
        else $error("overflow flag in infinity mode");

    // A saturated sum has the all-ones root.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '1)
        else $error("saturated sum with a partial root");

endmodule

bind weighted_vector_norm wvn_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wvn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int SW            = wvn_pkg::SAMPLE_WIDTH_DEF;
    localparam int NORM_W        = wvn_pkg::NORM_W;
    localparam int ACC_W         = wvn_pkg::ACC_W;
    localparam int TDATA_W       = ((2*SW+7)/8)*8;
    // Longest back-end latency (L2 root) plus margin before a mode write.
    localparam int SETTLE_CYCLES = 48;
    localparam int TAIL_CYCLES   = 60;
    localparam int PHASE_ELEMS   = 185;

    typedef enum logic [2:0] {ENT_ELEM, ENT_MODE, ENT_DRAIN, ENT_PHASE, ENT_HOLD} entry_kind_t;

    typedef struct packed {
        entry_kind_t           kind;
        logic signed [SW-1:0]  value;
        logic signed [SW-1:0]  weight;
        logic                  last;
        logic                  mode;
        int                    arg0;
        int                    arg1;
    } entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;     // element_value, element_weight
    logic               s_axis_tlast = 1'b0;   // last_element
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [NORM_W-1:0]  m_axis_tdata;          // norm_value
    logic               m_axis_tuser;          // overflowed

    weighted_vector_norm #(.SAMPLE_WIDTH(SW)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    entry_t               pending[$];
    wvn_pkg::wvn_result_t expected_norms[$];
    entry_t      cur;
    entry_t      on_bus;
    logic        holding = 1'b0;
    logic        feed_done = 1'b0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_cycles = 0;
    int          hold_left = 0;

    // Mirror of the block's statistics and mode register.
    logic                mode_now = wvn_pkg::MODE_INF;
    logic [2*SW-1:0]     peak_mag = '0;
    logic [ACC_W-1:0]    square_acc = '0;
    logic                square_sat = 1'b0;

    int fail_count = 0;
    int shown = 0;
    int n_elems = 0;
    int n_inf_vecs = 0;
    int n_l2_vecs = 0;
    int n_sat_vecs = 0;
    int n_checked = 0;

    function automatic logic [NORM_W-1:0] floor_root(input logic [ACC_W-1:0] x);
        logic [NORM_W-1:0] root;
        logic [NORM_W-1:0] trial;
        root = '0;
        for (int i = NORM_W - 1; i >= 0; i--)
        begin
            trial = root | (NORM_W'(1) << i);
            if (ACC_W'(trial) * ACC_W'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    // Updates the running statistics for one element and, on the last one,
    // queues the norm the block must produce.
    function automatic void fold_element(input logic signed [SW-1:0] v,
                                         input logic signed [SW-1:0] w,
                                         input logic last_el);
        logic signed [2*SW-1:0] prod;
        logic [2*SW-1:0]        mag;
        logic [ACC_W-1:0]       sq;
        logic [ACC_W:0]         sum_wide;
        logic [ACC_W-1:0]       norm_wide;
        wvn_pkg::wvn_result_t   res;
        prod = v * w;
        mag = prod[2*SW-1] ? -prod : prod;
        if (mag > peak_mag)
            peak_mag = mag;
        if (ACC_W'(mag) > ACC_W'(32'hFFFF_FFFF))
        begin
            square_acc = '1;
            square_sat = 1'b1;
        end
        else
        begin
            sq = ACC_W'(mag) * ACC_W'(mag);
            sum_wide = {1'b0, square_acc} + {1'b0, sq};
            if (sum_wide[ACC_W])
            begin
                square_acc = '1;
                square_sat = 1'b1;
            end
            else
                square_acc = sum_wide[ACC_W-1:0];
        end
        n_elems++;
        if (last_el)
        begin
            if (mode_now == wvn_pkg::MODE_L2)
            begin
                res.norm_value = floor_root(square_acc);
                res.overflowed = square_sat;
                n_l2_vecs++;
                if (square_sat)
                    n_sat_vecs++;
            end
            else
            begin
                norm_wide = ACC_W'(peak_mag);
                res.norm_value = (norm_wide > ACC_W'(32'hFFFF_FFFF)) ? '1 : norm_wide[NORM_W-1:0];
                res.overflowed = 1'b0;
                n_inf_vecs++;
            end
            expected_norms.push_back(res);
            peak_mag = '0;
            square_acc = '0;
            square_sat = 1'b0;
        end
    endfunction

    function automatic void put_elem(input int v, input int w, input logic last_el);
        entry_t e;
        e = '0;
        e.kind = ENT_ELEM;
        e.value = SW'(v);
        e.weight = SW'(w);
        e.last = last_el;
        pending.push_back(e);
    endfunction

    function automatic void put_ctl(input entry_kind_t kind, input logic mode,
                                    input int a0, input int a1);
        entry_t e;
        e = '0;
        e.kind = kind;
        e.mode = mode;
        e.arg0 = a0;
        e.arg1 = a1;
        pending.push_back(e);
    endfunction

    function automatic int pick_sample(input logic loud);
        int x;
        if (loud)
        begin
            x = (1 << (SW-1)) - 1 - int'($urandom_range(300));
            return $urandom_range(1) ? -x - 1 : x;
        end
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(4))
                0: x = -(1 << (SW-1));
                1: x = (1 << (SW-1)) - 1;
                2: x = 0;
                3: x = -1;
                default: x = 1;
            endcase
            return x;
        end
        return int'($urandom);
    endfunction

    // Queues one vector with random content and returns its length.
    function automatic int put_vector();
        int    len;
        logic  loud;
        loud = ($urandom_range(9) == 0);
        if (loud)
            len = $urandom_range(22, 17);
        else if ($urandom_range(2) == 0)
            len = 1;
        else
            len = $urandom_range(8, 2);
        for (int i = 0; i < len; i++)
            put_elem(pick_sample(loud), pick_sample(loud), i == len - 1);
        return len;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : feeder
        logic               next_valid;
        logic               next_cfg;
        logic               next_hold;
        logic [TDATA_W-1:0] packed_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            cfg_valid     <= 1'b0;
            cfg_data      <= '0;
            hold_req      <= 1'b0;
            hold_cycles   <= 0;
            idle_pct      <= 0;
            stall_pct     <= 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_cfg   = cfg_valid;
            next_hold  = 1'b0;
            if (expected_norms.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_element(on_bus.value, on_bus.weight, on_bus.last);
                next_valid = 1'b0;
                // The block may still be working on this element.
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                mode_now = on_bus.mode;
                next_cfg = 1'b0;
            end
            if (!next_valid && !next_cfg)
            begin
                if (!holding && pending.size() != 0)
                begin
                    cur = pending.pop_front();
                    holding = 1'b1;
                end
                if (holding)
                begin
                    case (cur.kind)
                        ENT_ELEM:
                            if ($urandom_range(99) >= idle_pct)
                            begin
                                packed_data = '0;
                                packed_data[SW-1:0] = cur.value;
                                packed_data[2*SW-1:SW] = cur.weight;
                                s_axis_tdata <= packed_data;
                                s_axis_tlast <= cur.last;
                                next_valid = 1'b1;
                                on_bus = cur;
                                holding = 1'b0;
                            end
                        ENT_MODE:
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                cfg_data <= cur.mode;
                                next_cfg = 1'b1;
                                on_bus = cur;
                                holding = 1'b0;
                            end
                        ENT_DRAIN:
                            if (expected_norms.size() == 0)
                                holding = 1'b0;
                        ENT_PHASE:
                        begin
                            idle_pct <= cur.arg0;
                            stall_pct <= cur.arg1;
                            holding = 1'b0;
                        end
                        default:
                        begin
                            hold_cycles <= cur.arg0;
                            next_hold = 1'b1;
                            holding = 1'b0;
                        end
                    endcase
                end
                if (!holding && !next_valid && !next_cfg && pending.size() == 0)
                    feed_done = 1'b1;
            end
            s_axis_tvalid <= next_valid;
            cfg_valid     <= next_cfg;
            hold_req      <= next_hold;
        end
    end

    // Long receiver hold-off, counted down here so the sender keeps pushing.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= hold_cycles;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wvn_pkg::wvn_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_norms.size() == 0)
                begin
                    fail_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("unexpected norm %h overflowed %b", m_axis_tdata, m_axis_tuser);
                    end
                end
                else
                begin
                    want = expected_norms.pop_front();
                    n_checked++;
                    if (m_axis_tdata !== want.norm_value || m_axis_tuser !== want.overflowed)
                    begin
                        fail_count++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("norm mismatch: expected %h/%b, got %h/%b",
                                     want.norm_value, want.overflowed,
                                     m_axis_tdata, m_axis_tuser);
                        end
                    end
                end
            end
            m_axis_tready <= !hold_req && hold_left == 0 && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int phase_elems;
        int idle_set[4];
        int stall_set[4];
        logic hold_put;
        logic drain_put;
        idle_set  = '{0, 61, 0, 35};
        stall_set = '{0, 0, 61, 35};
        hold_put  = 1'b0;
        drain_put = 1'b0;

        // Directed vectors: extremes in both modes, a mode change inside a
        // vector, and a squared sum driven into saturation.
        put_ctl(ENT_PHASE, wvn_pkg::MODE_INF, 0, 0);
        put_ctl(ENT_MODE, wvn_pkg::MODE_INF, 0, 0);
        put_elem(-32768, -32768, 1'b1);
        put_elem(32767, -32768, 1'b1);
        put_elem(0, 0, 1'b1);
        put_elem(1, -1, 1'b0);
        put_elem(-1, 1, 1'b1);
        put_ctl(ENT_MODE, wvn_pkg::MODE_L2, 0, 0);
        put_elem(-32768, -32768, 1'b1);
        put_elem(0, 0, 1'b1);
        put_elem(32767, 32767, 1'b0);
        put_elem(-32768, 32767, 1'b1);
        put_elem(1000, 2000, 1'b0);
        put_ctl(ENT_MODE, wvn_pkg::MODE_INF, 0, 0);
        put_elem(-5, 7, 1'b1);
        put_ctl(ENT_MODE, wvn_pkg::MODE_L2, 0, 0);
        for (int i = 0; i < 16; i++)
            put_elem(-32768, -32768, i == 15);
        put_ctl(ENT_DRAIN, wvn_pkg::MODE_INF, 0, 0);

        for (int p = 0; p < 4; p++)
        begin
            put_ctl(ENT_MODE, p[0] ? wvn_pkg::MODE_L2 : wvn_pkg::MODE_INF, 0, 0);
            put_ctl(ENT_PHASE, wvn_pkg::MODE_INF, idle_set[p], stall_set[p]);
            phase_elems = 0;
            while (phase_elems < PHASE_ELEMS)
            begin
                if (p == 0 && !hold_put && phase_elems >= 60)
                begin
                    // Receiver blocks while short vectors keep arriving.
                    put_ctl(ENT_HOLD, wvn_pkg::MODE_INF, 300, 0);
                    for (int i = 0; i < 12; i++)
                        put_elem(pick_sample(1'b0), pick_sample(1'b0), 1'b1);
                    phase_elems += 12;
                    hold_put = 1'b1;
                end
                if (p == 2 && !drain_put && phase_elems >= 90)
                begin
                    put_ctl(ENT_DRAIN, wvn_pkg::MODE_INF, 0, 0);
                    drain_put = 1'b1;
                end
                if ($urandom_range(11) == 0)
                    put_ctl(ENT_MODE, $urandom_range(1) ? wvn_pkg::MODE_L2 : wvn_pkg::MODE_INF,
                            0, 0);
                phase_elems += put_vector();
            end
            put_ctl(ENT_DRAIN, wvn_pkg::MODE_INF, 0, 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (feed_done);
        while (expected_norms.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d elements streamed, %0d norms checked (%0d infinity, %0d L2)",
                 n_elems, n_checked, n_inf_vecs, n_l2_vecs);
        $display("%0d L2 vectors saturated the square sum, %0d failures",
                 n_sat_vecs, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
